// ===== design/sponge_layer_tracer_relax_unit_defines.svh =====
// Assertion helpers for the top block, which checks itself.
`ifndef SPONGE_LAYER_TRACER_RELAX_UNIT_DEFINES_SVH
`define SPONGE_LAYER_TRACER_RELAX_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define SLRT_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("same-cycle check failed");

// Condition holds in the cycle after the trigger.
`define SLRT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("next-cycle check failed");

`endif

// ===== design/slrt_pkg.sv =====
`timescale 1ns / 1ps
package slrt_pkg;

  // Number of tracer lanes carried on the ports.
  localparam int LANES = 3;
  // Denominator width: h + (damp*h >> 16) + max(wb,0) - min(w,0) stays below 2^36.
  localparam int DEN_W = 37;
  // Magnitude of (T - R) * h stays below 2^63.
  localparam int DVD_W = 64;
  // Divider iterations per lane, each retiring two quotient bits.
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int CNT_W = $clog2(DIV_STEPS);

  // Register indexes, taken from address bit 2.
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_MINTH  = 1'b1;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic              column_start;
    logic [30:0]       basin_depth;
    logic [19:0]       damp_factor;
    logic [30:0]       layer_thickness;
    logic signed [31:0] ref_interface;
    logic signed [31:0] tracer_in_0;
    logic signed [31:0] tracer_in_1;
    logic signed [31:0] tracer_in_2;
    logic signed [31:0] ref_tracer_0;
    logic signed [31:0] ref_tracer_1;
    logic signed [31:0] ref_tracer_2;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tracer_out_0;
    logic signed [31:0] tracer_out_1;
    logic signed [31:0] tracer_out_2;
    logic               divide_fault;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  active_tracers;
    logic [15:0] min_thickness;
  } cfg_t;

  // One classified layer, handed from the front to the back.
  typedef struct packed {
    logic [DEN_W-1:0]         den;
    logic [30:0]              h;
    logic [LANES-1:0][31:0]   tr;
    logic [LANES-1:0][31:0]   rf;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] res;
    if (x > 66'(SAT_MAX)) res = SAT_MAX;
    else if (x < 66'(SAT_MIN)) res = SAT_MIN;
    else res = x[31:0];
    return res;
  endfunction

endpackage

// ===== design/sponge_layer_tracer_relax_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// in       | in_push / in_full         | in_data (in_item_t)
// out      | out_pop / out_empty       | out_data (out_item_t)
// cfg      | cfg_psel, cfg_penable     | cfg_paddr, cfg_pwdata, cfg_prdata
//
// The front takes one item at a time: it forms the interface height, the
// capped flux and the denominator, and it holds the column state.
// The back relaxes the lanes in turn with one shared radix-4 divider; a lane
// that is inactive or has a zero denominator does not use the divider.
// A two-entry queue lets the front run ahead; the output register holds a
// result until popped while the back works on the next item.
// Reset is synchronous and active low; it clears the column state at once.
module sponge_layer_tracer_relax_unit #(
  parameter int TRACERS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slrt_pkg::in_item_t  in_data,
  input  logic                in_push,
  output logic                in_full,
  output slrt_pkg::out_item_t out_data,
  output logic                out_empty,
  input  logic                out_pop,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

`include "sponge_layer_tracer_relax_unit_defines.svh"

  slrt_pkg::cfg_t   cfg_r;
  slrt_pkg::job_t   front_job, head_job;
  slrt_pkg::qstat_t qstat;
  logic             job_push, job_pop, cfg_wr;

  // Configuration registers.
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_tracers <= 2'd3;
      cfg_r.min_thickness  <= 16'd66;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        slrt_pkg::REG_ACTIVE: cfg_r.active_tracers <= cfg_pwdata[1:0];
        slrt_pkg::REG_MINTH:  cfg_r.min_thickness  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      slrt_pkg::REG_ACTIVE: cfg_prdata = {30'd0, cfg_r.active_tracers};
      slrt_pkg::REG_MINTH:  cfg_prdata = {16'd0, cfg_r.min_thickness};
      default:              cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  slrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .cfg      (cfg_r),
    .qstat    (qstat),
    .job      (front_job),
    .job_push (job_push)
  );

  slrt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_job (front_job),
    .wr_en  (job_push),
    .rd_en  (job_pop),
    .rd_job (head_job),
    .qstat  (qstat)
  );

  slrt_back #(.TRACERS(TRACERS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .qstat     (qstat),
    .job_pop   (job_pop),
    .cfg       (cfg_r),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  // The front works on one item at a time.
  `SLRT_ASSERT_NEXT(a_front_busy, clk, rst_n, in_push && !in_full, in_full)
  // The queue never takes an item while full or gives one while empty.
  `SLRT_ASSERT_SAME(a_queue_guard, clk, rst_n, job_push || job_pop,
                    !(job_push && qstat.full) && !(job_pop && qstat.empty))
  // A fault needs at least one relaxed lane.
  `SLRT_ASSERT_SAME(a_fault_lanes, clk, rst_n, !out_empty && out_data.divide_fault,
                    cfg_r.active_tracers != 2'd0)

endmodule

// ===== design/slrt_front.sv =====
`timescale 1ns / 1ps
module slrt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  slrt_pkg::in_item_t in_data,
  input  logic              in_push,
  output logic              in_full,
  input  slrt_pkg::cfg_t    cfg,
  input  slrt_pkg::qstat_t  qstat,
  output slrt_pkg::job_t    job,
  output logic              job_push
);

  localparam int DEN_W_L = slrt_pkg::DEN_W;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_E    = 5'b00010,
    F_MUL  = 5'b00100,
    F_CAP  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;
  slrt_pkg::in_item_t item_r;
  slrt_pkg::job_t     job_r;
  logic signed [31:0] e_r, wb_r, cap_r, ih_r, fb_r;
  logic [50:0]        damph_r;
  logic signed [53:0] wdp_r;

  logic signed [32:0] base_w, wb_w, sum_e;
  logic signed [33:0] cap_sum;
  logic signed [32:0] diff_e;
  logic signed [31:0] wd, w;
  logic [32:0]        neg_wm;
  logic [30:0]        wpb;
  logic [DEN_W_L-1:0] den_w;

  // Running state of the column, overridden on the bottom layer.
  always_comb begin
    base_w = item_r.column_start ? -$signed({2'b00, item_r.basin_depth}) : 33'(ih_r);
    wb_w   = item_r.column_start ? 33'sd0 : 33'(fb_r);
    sum_e  = base_w + $signed({2'b00, item_r.layer_thickness});
    diff_e = 33'(e_r) - 33'(item_r.ref_interface);
    cap_sum = 34'(wb_r) + $signed({3'b000, item_r.layer_thickness})
            - $signed({18'd0, cfg.min_thickness});
  end

  // Capped flux and the relaxation denominator.
  always_comb begin
    wd     = slrt_pkg::sat32(66'(wdp_r >>> 16));
    w      = (wd < cap_r) ? wd : cap_r;
    neg_wm = (w < 0) ? 33'(-(33'(w))) : 33'd0;
    wpb    = (wb_r > 0) ? wb_r[30:0] : 31'd0;
    den_w  = DEN_W_L'(item_r.layer_thickness) + DEN_W_L'(damph_r[50:16])
           + DEN_W_L'(wpb) + DEN_W_L'(neg_wm);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_push) state_nxt = F_E;
      F_E:    state_nxt = F_MUL;
      F_MUL:  state_nxt = F_CAP;
      F_CAP:  state_nxt = F_PUSH;
      F_PUSH: if (!qstat.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      ih_r    <= '0;
      fb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_CAP) begin
        ih_r <= e_r;
        fb_r <= w;
      end
    end
  end

  // Datapath registers, one step per state.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_push) item_r <= in_data;
    if (state_r == F_E) begin
      e_r     <= slrt_pkg::sat32(66'(sum_e));
      wb_r    <= wb_w[31:0];
      damph_r <= 51'(item_r.damp_factor) * 51'(item_r.layer_thickness);
    end
    if (state_r == F_MUL) begin
      wdp_r <= 54'(diff_e) * 54'($signed({1'b0, item_r.damp_factor}));
      cap_r <= slrt_pkg::sat32(66'(cap_sum));
    end
    if (state_r == F_CAP) begin
      job_r.den   <= den_w;
      job_r.h     <= item_r.layer_thickness;
      job_r.tr[0] <= item_r.tracer_in_0;
      job_r.tr[1] <= item_r.tracer_in_1;
      job_r.tr[2] <= item_r.tracer_in_2;
      job_r.rf[0] <= item_r.ref_tracer_0;
      job_r.rf[1] <= item_r.ref_tracer_1;
      job_r.rf[2] <= item_r.ref_tracer_2;
    end
  end

  assign in_full  = (state_r != F_IDLE);
  assign job_push = (state_r == F_PUSH) && !qstat.full;
  assign job      = job_r;

endmodule

// ===== design/slrt_queue.sv =====
`timescale 1ns / 1ps
module slrt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  slrt_pkg::job_t   wr_job,
  input  logic             wr_en,
  input  logic             rd_en,
  output slrt_pkg::job_t   rd_job,
  output slrt_pkg::qstat_t qstat
);

  // Two entries in flip-flops.
  slrt_pkg::job_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      if (wr_en && !rd_en) count_r <= count_r + 2'd1;
      else if (rd_en && !wr_en) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_job;
  end

  assign rd_job      = mem_r[rd_ptr_r];
  assign qstat.full  = (count_r == 2'd2);
  assign qstat.empty = (count_r == 2'd0);

endmodule

// ===== design/slrt_back.sv =====
`timescale 1ns / 1ps
module slrt_back #(
  parameter int TRACERS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  slrt_pkg::job_t     job,
  input  slrt_pkg::qstat_t   qstat,
  output logic               job_pop,
  input  slrt_pkg::cfg_t     cfg,
  output slrt_pkg::out_item_t out_data,
  output logic               out_empty,
  input  logic               out_pop
);

  localparam int DEN_W = slrt_pkg::DEN_W;
  localparam int DVD_W = slrt_pkg::DVD_W;
  localparam int CNT_W = slrt_pkg::CNT_W;
  localparam int LIM   = (TRACERS < slrt_pkg::LANES) ? TRACERS : slrt_pkg::LANES;
  localparam logic [1:0] LANE_LIM = 2'(LIM);
  localparam logic [1:0] LAST_LANE = 2'(slrt_pkg::LANES - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(slrt_pkg::DIV_STEPS - 1);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_START = 7'b0000010,
    B_ABS   = 7'b0000100,
    B_DIV   = 7'b0001000,
    B_FIX   = 7'b0010000,
    B_NEXT  = 7'b0100000,
    B_OUT   = 7'b1000000
  } bstate_t;

  bstate_t state_r, state_nxt;
  slrt_pkg::job_t job_r;
  logic [1:0]             lane_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   fault_r, neg_r, out_valid_r;
  logic signed [63:0]     prod_r;
  logic [DVD_W-1:0]       q_r;
  logic [DEN_W-1:0]       rem_r;
  logic [slrt_pkg::LANES-1:0][31:0] res_r;
  slrt_pkg::out_item_t    out_r;

  logic [1:0]         lanes;
  logic               lane_on;
  logic signed [31:0] t_l, r_l;
  logic signed [32:0] diff_l;
  logic [DEN_W:0]     r1, r2;
  logic [DEN_W-1:0]   s1;
  logic               b1, b2;
  logic [DVD_W-1:0]   q_nxt;
  logic signed [65:0] qs, sum_l;

  // Lanes that are relaxed this item.
  assign lanes   = (cfg.active_tracers < LANE_LIM) ? cfg.active_tracers : LANE_LIM;
  assign lane_on = ({1'b0, lane_r} < {1'b0, lanes});
  assign t_l     = job_r.tr[lane_r];
  assign r_l     = job_r.rf[lane_r];
  assign diff_l  = 33'(t_l) - 33'(r_l);

  // Two restoring division steps per cycle.
  always_comb begin
    r1 = {rem_r, q_r[DVD_W-1]};
    b1 = (r1 >= {1'b0, job_r.den});
    s1 = b1 ? DEN_W'(r1 - {1'b0, job_r.den}) : r1[DEN_W-1:0];
    r2 = {s1, q_r[DVD_W-2]};
    b2 = (r2 >= {1'b0, job_r.den});
    q_nxt = {q_r[DVD_W-3:0], b1, b2};
  end

  // Signed quotient added to the reference.
  always_comb begin
    qs    = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
    sum_l = 66'(r_l) + qs;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!qstat.empty) state_nxt = B_START;
      B_START: begin
        if (lane_on && job_r.den != '0) state_nxt = B_ABS;
        else state_nxt = B_NEXT;
      end
      B_ABS:   state_nxt = B_DIV;
      B_DIV:   if (cnt_r == LAST_CNT) state_nxt = B_FIX;
      B_FIX:   state_nxt = B_NEXT;
      B_NEXT:  state_nxt = (lane_r == LAST_LANE) ? B_OUT : B_START;
      B_OUT:   if (!out_valid_r) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_OUT && !out_valid_r) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // Lane sequencing and the shared divider.
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        job_r   <= job;
        lane_r  <= 2'd0;
        fault_r <= 1'b0;
      end
      B_START: begin
        prod_r <= 64'(diff_l) * 64'($signed({2'b00, job_r.h}));
        if (!lane_on) begin
          res_r[lane_r] <= t_l;
        end else if (job_r.den == '0) begin
          fault_r       <= 1'b1;
          res_r[lane_r] <= t_l[31] ? slrt_pkg::SAT_MIN : slrt_pkg::SAT_MAX;
        end
      end
      B_ABS: begin
        neg_r <= prod_r[63];
        q_r   <= prod_r[63] ? DVD_W'(-prod_r) : DVD_W'(prod_r);
        rem_r <= '0;
        cnt_r <= '0;
      end
      B_DIV: begin
        q_r   <= q_nxt;
        rem_r <= b2 ? DEN_W'(r2 - {1'b0, job_r.den}) : r2[DEN_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
      end
      B_FIX: res_r[lane_r] <= slrt_pkg::sat32(sum_l);
      B_NEXT: if (lane_r != LAST_LANE) lane_r <= lane_r + 2'd1;
      B_OUT: begin
        if (!out_valid_r) begin
          out_r.tracer_out_0 <= res_r[0];
          out_r.tracer_out_1 <= res_r[1];
          out_r.tracer_out_2 <= res_r[2];
          out_r.divide_fault <= fault_r;
        end
      end
      default: ;
    endcase
  end

  assign job_pop   = (state_r == B_IDLE) && !qstat.empty;
  assign out_data  = out_r;
  assign out_empty = !out_valid_r;

endmodule

// ===== verif/sponge_layer_tracer_relax_unit_checker.sv =====
`timescale 1ns / 1ps
module sponge_layer_tracer_relax_unit_checker #(
  parameter int TRACERS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slrt_pkg::in_item_t  in_data,
  input  logic                in_push,
  input  logic                in_full,
  input  slrt_pkg::out_item_t out_data,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  pending
);

  // Shadow copy of the column state and the registers.
  longint      height_q;
  longint      flux_q;
  logic [1:0]  active_q;
  logic [15:0] min_th_q;

  slrt_pkg::out_item_t relaxed_q[$];

  function automatic longint clamp32(input longint x);
    longint res;
    if (x > 64'sd2147483647) res = 64'sd2147483647;
    else if (x < -64'sd2147483648) res = -64'sd2147483648;
    else res = x;
    return res;
  endfunction

  // Predicts the relaxed lanes of one layer and advances the column state.
  function automatic slrt_pkg::out_item_t relax_layer(input slrt_pkg::in_item_t it);
    longint    h, damp, depth, ref_if, base, wb, e, wd, cap, w, wm, wpb, den;
    longint    tv[3], rv[3], res[3];
    int        lanes;
    bit        fault;
    slrt_pkg::out_item_t o;
    h      = longint'(it.layer_thickness);
    damp   = longint'(it.damp_factor);
    depth  = longint'(it.basin_depth);
    ref_if = longint'(it.ref_interface);
    tv[0] = longint'(it.tracer_in_0);
    tv[1] = longint'(it.tracer_in_1);
    tv[2] = longint'(it.tracer_in_2);
    rv[0] = longint'(it.ref_tracer_0);
    rv[1] = longint'(it.ref_tracer_1);
    rv[2] = longint'(it.ref_tracer_2);
    base = it.column_start ? -depth : height_q;
    wb   = it.column_start ? 0 : flux_q;
    e    = clamp32(base + h);
    // Arithmetic shift floors toward minus infinity.
    wd   = clamp32(((e - ref_if) * damp) >>> 16);
    cap  = clamp32(wb + h - longint'(min_th_q));
    w    = (wd < cap) ? wd : cap;
    wm   = (w < 0) ? w : 0;
    wpb  = (wb > 0) ? wb : 0;
    den  = h + ((damp * h) >>> 16) + wpb - wm;
    lanes = int'(active_q);
    if (lanes > TRACERS) lanes = TRACERS;
    if (lanes > slrt_pkg::LANES) lanes = slrt_pkg::LANES;
    fault = 1'b0;
    for (int l = 0; l < 3; l++) begin
      res[l] = tv[l];
      if (l < lanes) begin
        if (den == 0) begin
          fault = 1'b1;
          res[l] = (tv[l] >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        end else begin
          res[l] = clamp32(rv[l] + ((tv[l] - rv[l]) * h) / den);
        end
      end
    end
    o.tracer_out_0 = res[0][31:0];
    o.tracer_out_1 = res[1][31:0];
    o.tracer_out_2 = res[2][31:0];
    o.divide_fault = fault;
    height_q = e;
    flux_q   = w;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = relaxed_q.size();

  // Track register writes, predict accepted items and check popped results.
  always @(posedge clk) begin
    slrt_pkg::out_item_t want;
    if (!rst_n) begin
      height_q   <= 0;
      flux_q     <= 0;
      active_q   <= 2'd3;
      min_th_q   <= 16'd66;
      fail_count <= 0;
      relaxed_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == slrt_pkg::REG_ACTIVE) active_q <= cfg_pwdata[1:0];
        else min_th_q <= cfg_pwdata[15:0];
      end
      if (in_push && !in_full) relaxed_q.push_back(relax_layer(in_data));
      if (out_pop && !out_empty) begin
        if (relaxed_q.size() == 0) begin
          report_mismatch("unexpected item", out_data[32:1], 32'h0);
        end else begin
          want = relaxed_q.pop_front();
          if (out_data.tracer_out_0 !== want.tracer_out_0)
            report_mismatch("tracer_out_0", out_data.tracer_out_0, want.tracer_out_0);
          if (out_data.tracer_out_1 !== want.tracer_out_1)
            report_mismatch("tracer_out_1", out_data.tracer_out_1, want.tracer_out_1);
          if (out_data.tracer_out_2 !== want.tracer_out_2)
            report_mismatch("tracer_out_2", out_data.tracer_out_2, want.tracer_out_2);
          if (out_data.divide_fault !== want.divide_fault)
            report_mismatch("divide_fault", 32'(out_data.divide_fault),
                            32'(want.divide_fault));
        end
      end
    end
  end
endmodule

// ===== verif/sponge_layer_tracer_relax_unit_tb.sv =====
`timescale 1ns / 1ps
module sponge_layer_tracer_relax_unit_tb;

  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  slrt_pkg::in_item_t  in_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  slrt_pkg::out_item_t out_data;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  int          column_left = 0;

  sponge_layer_tracer_relax_unit dut (.*);

  sponge_layer_tracer_relax_unit_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side stalls in random bursts until the calm tail of the run.
  always @(posedge clk) begin
    int stall_left;
    if (stall_left > 0) begin
      out_pop <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      out_pop <= 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Watchdog: too many cycles without any accepted or popped item ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("[sponge_layer_tracer_relax_unit] ERROR");
    $finish;
  end

  task automatic push_layer(input slrt_pkg::in_item_t it);
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drain all outstanding items, then change both registers.
  task automatic set_config(input logic [1:0] lanes, input logic [15:0] eps);
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    write_reg(slrt_pkg::REG_ACTIVE, 32'(lanes));
    write_reg(slrt_pkg::REG_MINTH, 32'(eps));
  endtask

  // Mostly well-formed columns with plausible sizes, some raw noise.
  function automatic slrt_pkg::in_item_t random_layer();
    slrt_pkg::in_item_t it;
    logic [319:0]       raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    it = raw[306:0];
    if ($urandom_range(0, 9) < 3) return it;
    it.column_start = (column_left == 0);
    if (column_left == 0) column_left = $urandom_range(1, 12);
    column_left--;
    it.basin_depth     = 31'($urandom_range(0, 32'h0100_0000));
    it.layer_thickness = 31'($urandom_range(0, 32'h0040_0000));
    it.damp_factor     = 20'($urandom_range(0, 32'h0002_0000));
    it.ref_interface   = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    if ($urandom_range(0, 1) == 0) begin
      it.tracer_in_0  = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      it.ref_tracer_0 = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    end
    if ($urandom_range(0, 19) == 0) it.layer_thickness = '0;
    if ($urandom_range(0, 19) == 0) it.damp_factor = '0;
    return it;
  endfunction

  // Directed layers: field extremes, saturation and zero denominators.
  task automatic directed_layers();
    slrt_pkg::in_item_t it;
    it = '0;
    it.column_start = 1'b1;
    push_layer(it);
    it.tracer_in_0 = slrt_pkg::SAT_MIN;
    it.tracer_in_1 = 32'sd5;
    it.tracer_in_2 = slrt_pkg::SAT_MAX;
    push_layer(it);
    it = '1;
    push_layer(it);
    it.column_start = 1'b0;
    push_layer(it);
    it.ref_interface = slrt_pkg::SAT_MIN;
    it.tracer_in_0 = slrt_pkg::SAT_MAX;
    it.ref_tracer_0 = slrt_pkg::SAT_MIN;
    it.tracer_in_1 = slrt_pkg::SAT_MIN;
    it.ref_tracer_1 = slrt_pkg::SAT_MAX;
    push_layer(it);
    it.ref_interface = slrt_pkg::SAT_MAX;
    it.column_start = 1'b1;
    it.basin_depth = 31'h7FFF_FFFF;
    it.layer_thickness = 31'd1;
    push_layer(it);
    it.column_start = 1'b0;
    it.damp_factor = 20'd0;
    push_layer(it);
    // Zero thickness at a column start with no damping divides by zero.
    it = '0;
    it.column_start = 1'b1;
    it.tracer_in_0 = -32'sd1;
    it.tracer_in_1 = 32'sd0;
    it.tracer_in_2 = 32'sd7;
    it.basin_depth = 31'd100;
    push_layer(it);
    it.damp_factor = 20'hFFFFF;
    it.ref_interface = slrt_pkg::SAT_MIN;
    push_layer(it);
    it.column_start = 1'b0;
    it.layer_thickness = 31'h0001_0000;
    it.damp_factor = 20'h10000;
    it.ref_interface = 32'sh0001_0000;
    push_layer(it);
    it.layer_thickness = 31'd0;
    push_layer(it);
  endtask

  initial begin
    logic [1:0]  lane_set[6] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3};
    logic [15:0] eps_set[6]  = '{16'd0, 16'hFFFF, 16'd66, 16'd0, 16'hFFFF, 16'd1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 6; p++) begin
      calm = (p == 5);
      set_config(lane_set[p], eps_set[p]);
      if (p == 0 || p == 3) directed_layers();
      repeat (130) push_layer(random_layer());
    end
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("[sponge_layer_tracer_relax_unit] OK");
    else $display("[sponge_layer_tracer_relax_unit] ERROR");
    $finish;
  end
endmodule
